// ----- rtl/vsd_pkg.sv -----
// ----------------------------------------------------------------------------
// vsd_pkg
// Types and constants shared by the varint stream decoder modules.
// ----------------------------------------------------------------------------
package vsd_pkg;

    localparam int VALUE_W  = 64;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANONICAL_ONLY = 1'd1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONCANON  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED = 2'd3;

    // last allowed byte position and its exclusive upper bound
    localparam logic [POS_W-1:0] LAST_POS_NARROW = 4'd4;
    localparam logic [POS_W-1:0] LAST_POS_WIDE   = 4'd9;
    localparam logic [7:0]       LIMIT_NARROW    = 8'd16;
    localparam logic [7:0]       LIMIT_WIDE      = 8'd2;

    localparam logic [7:0] CONT_BIT = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       input_end;
    } vsd_in_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  decoded_value;
        logic [POS_W-1:0]    encoded_length;
        logic [STATUS_W-1:0] status;
    } vsd_out_t;

    typedef struct packed {
        logic wide_mode;
        logic canonical_only;
    } vsd_cfg_t;

    // step result: one optional output beat plus the next accumulator state
    typedef struct packed {
        logic               emit;
        vsd_out_t           result;
        logic [VALUE_W-1:0] next_partial;
        logic [POS_W-1:0]   next_pos;
    } vsd_step_t;

endpackage

// ----- rtl/vsd_step.sv -----
// ----------------------------------------------------------------------------
// vsd_step
// Decode logic for one byte: merges the byte into the running value and
// decides whether the varint ends here and with which status.
// ----------------------------------------------------------------------------
module vsd_step
    import vsd_pkg::*;
(
    input  vsd_cfg_t           cfg,
    input  vsd_in_t            in_beat,
    input  logic [VALUE_W-1:0] partial,
    input  logic [POS_W-1:0]   pos,
    output vsd_step_t          step
);

    logic [POS_W-1:0]   last_pos;
    logic [7:0]         limit;
    logic [6:0]         shamt;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   len;
    logic [7:0]         b;

    assign b        = in_beat.data_byte;
    assign last_pos = cfg.wide_mode ? LAST_POS_WIDE : LAST_POS_NARROW;
    assign limit    = cfg.wide_mode ? LIMIT_WIDE : LIMIT_NARROW;
    assign shamt    = 7'({3'd0, pos} * 7'd7);
    assign value    = partial | ({{(VALUE_W-7){1'b0}}, b[6:0]} << shamt);
    assign len      = pos + 4'd1;

    always_comb begin
        step.emit                  = 1'b1;
        step.result.decoded_value  = '0;
        step.result.encoded_length = len;
        step.result.status         = ST_OK;
        step.next_partial          = '0;
        step.next_pos              = '0;

        if (pos > last_pos) begin
            // mode was narrowed mid-varint
            step.result.status = ST_OVERFLOW;
        end else if (pos == last_pos && b >= limit) begin
            step.result.status = ST_OVERFLOW;
        end else if (pos != last_pos && b >= CONT_BIT) begin
            if (in_beat.input_end) begin
                step.result.status = ST_TRUNCATED;
            end else begin
                step.emit         = 1'b0;
                step.next_partial = value;
                step.next_pos     = len;
            end
        end else if (cfg.canonical_only && pos != '0 && b == 8'd0) begin
            step.result.status = ST_NONCANON;
        end else begin
            step.result.decoded_value = value;
        end
    end

endmodule

// ----- rtl/vsd_out_reg.sv -----
// ----------------------------------------------------------------------------
// vsd_out_reg
// Result register: holds one output beat and frees itself in the cycle the
// beat is taken, so a new result can load at the same edge.
// ----------------------------------------------------------------------------
module vsd_out_reg
    import vsd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     load,
    input  vsd_out_t load_data,
    output logic     can_load,
    output logic     m_valid,
    input  logic     m_ready,
    output vsd_out_t m_data
);

    logic     valid_reg;
    logic     valid_next;
    vsd_out_t data_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ----- rtl/varint_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// varint_stream_decoder
// Streaming LEB128 varint decoder, one encoded byte per input beat.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while s_ready is high. It emits one result beat
// (value, length, status) on the byte that ends each varint or fails it. Each
// byte is merged into a 64-bit running value by a single shift-and-or stage. A
// result enters the output register at the same edge that takes its byte. The
// output register frees itself in the cycle its beat is taken. While a finished
// result waits with m_ready low, s_ready is low as well, even for bytes that
// would not end a varint. Without backpressure a byte is taken every cycle.
// A varint in progress survives register writes; later bytes use new settings.
module varint_stream_decoder
    import vsd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  vsd_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output vsd_out_t              m_data
);

    vsd_cfg_t           cfg_reg;
    vsd_cfg_t           cfg_next;
    logic [VALUE_W-1:0] partial_reg;
    logic [POS_W-1:0]   pos_reg;
    vsd_step_t          step;
    logic               accept;
    logic               can_load;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_WIDE_MODE:      cfg_next.wide_mode      = cfg_wdata[0];
                CFG_CANONICAL_ONLY: cfg_next.canonical_only = cfg_wdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wide_mode      <= 1'b1;
            cfg_reg.canonical_only <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    vsd_step u_step (
        .cfg     (cfg_reg),
        .in_beat (s_data),
        .partial (partial_reg),
        .pos     (pos_reg),
        .step    (step)
    );

    assign s_ready = can_load;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            pos_reg     <= '0;
        end else if (accept) begin
            partial_reg <= step.next_partial;
            pos_reg     <= step.next_pos;
        end
    end

    vsd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept && step.emit),
        .load_data (step.result),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for varint_stream_decoder.
// ----------------------------------------------------------------------------
// Drives encoded bytes on the s_ channel and checks every result beat on the
// m_ channel against a cycle-free decoder model kept in the bench. Directed
// cases cover value extremes, truncation, the last-byte overflow limit in both
// modes, non-canonical zero terminators and a mode change in the middle of a
// varint. Random phases then run mostly well-formed varints with truncated
// ones and noise mixed in, under several register settings, with random
// source gaps and sink stalls in all phases but the last.
// ----------------------------------------------------------------------------
module tb_top
    import vsd_pkg::*;
;

    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT  = 2000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    vsd_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    vsd_out_t              m_data;

    varint_stream_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // decoder model state and registers
    logic               model_wide;
    logic               model_canon;
    logic [VALUE_W-1:0] acc_value;
    logic [POS_W-1:0]   acc_pos;

    vsd_out_t expected_varints[$];
    vsd_out_t want;
    int       fail_count   = 0;
    bit       idling_on    = 1'b1;
    int       stall_left   = 0;
    int       quiet_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Advances the model by one byte; returns 1 when the byte ends a varint.
    function automatic bit decode_byte(input vsd_in_t beat, output vsd_out_t res);
        logic [POS_W-1:0]    last_pos;
        logic [7:0]          limit;
        logic [VALUE_W-1:0]  merged;
        logic [STATUS_W-1:0] st;
        bit                  done;
        last_pos = model_wide ? LAST_POS_WIDE : LAST_POS_NARROW;
        limit    = model_wide ? LIMIT_WIDE : LIMIT_NARROW;
        merged   = acc_value | ({57'd0, beat.data_byte[6:0]} << (7 * acc_pos));
        done     = 1'b1;
        st       = ST_OK;
        if (acc_pos > last_pos) begin
            st = ST_OVERFLOW;
        end else if (acc_pos == last_pos) begin
            // last allowed byte ends the varint regardless of its top bit
            if (beat.data_byte >= limit) st = ST_OVERFLOW;
        end else if ((beat.data_byte & CONT_BIT) != 0) begin
            if (beat.input_end) st = ST_TRUNCATED;
            else done = 1'b0;
        end
        if (done && st == ST_OK && model_canon && acc_pos != 0 && beat.data_byte == 8'h00)
            st = ST_NONCANON;
        res.decoded_value  = (st == ST_OK) ? merged : '0;
        res.encoded_length = acc_pos + 1'b1;
        res.status         = st;
        if (done) begin
            acc_value = '0;
            acc_pos   = '0;
        end else begin
            acc_value = merged;
            acc_pos   = acc_pos + 1'b1;
        end
        return done;
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic last_in);
        vsd_out_t res;
        int       gap;
        @(negedge aclk);
        if (idling_on && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 16);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data.data_byte = data;
        s_data.input_end = last_in;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (decode_byte(s_data, res)) expected_varints.push_back(res);
    endtask

    task automatic wait_idle;
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_varints.size() != 0) @(posedge aclk);
        // a byte that ends nothing may still be in flight
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        s_valid   = 1'b0;
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (idx == CFG_WIDE_MODE) model_wide = val[0];
        else model_canon = val[0];
    endtask

    task automatic set_config(input logic wide, input logic canon);
        wait_idle();
        write_reg(CFG_WIDE_MODE, wide);
        write_reg(CFG_CANONICAL_ONLY, canon);
    endtask

    // reset settings: 64-bit, non-canonical accepted
    task automatic test_wide_defaults;
        int i;
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        for (i = 0; i < 9; i++) send_byte(8'hff, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hff, 1'b1);
    endtask

    task automatic test_narrow_limits;
        int i;
        set_config(1'b0, 1'b0);
        for (i = 0; i < 4; i++) send_byte(8'hff, 1'b0);
        send_byte(8'h0f, 1'b0);
        for (i = 0; i < 4; i++) send_byte(8'h80, 1'b0);
        send_byte(8'h90, 1'b1);
    endtask

    task automatic test_canonical_form;
        int i;
        set_config(1'b1, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        for (i = 0; i < 9; i++) send_byte(8'h80, 1'b0);
        send_byte(8'h02, 1'b0);
    endtask

    // narrowing the mode past the current position overflows on the next byte
    task automatic test_mode_switch_mid_varint;
        int i;
        set_config(1'b1, 1'b0);
        for (i = 0; i < 5; i++) send_byte(8'h80, 1'b0);
        set_config(1'b0, 1'b0);
        send_byte(8'h05, 1'b0);
    endtask

    task automatic test_random_stream(input int n_bytes);
        int               sent;
        int               kind;
        int               len;
        int               cut;
        int               i;
        logic [POS_W-1:0] last_pos;
        logic [7:0]       limit;
        logic [7:0]       b;
        sent = 0;
        while (sent < n_bytes) begin
            last_pos = model_wide ? LAST_POS_WIDE : LAST_POS_NARROW;
            limit    = model_wide ? LIMIT_WIDE : LIMIT_NARROW;
            kind     = $urandom_range(0, 99);
            if (kind < 10) begin
                len = $urandom_range(1, 3);
                for (i = 0; i < len; i++) begin
                    b = 8'($urandom_range(0, 255));
                    send_byte(b, 1'($urandom_range(0, 1)));
                end
                sent += len;
            end else if (kind < 20) begin
                // continuation bytes cut short by input end
                cut = $urandom_range(1, last_pos);
                for (i = 0; i < cut; i++) begin
                    b = 8'($urandom_range(0, 127));
                    b[7] = 1'b1;
                    send_byte(b, i == cut - 1);
                end
                sent += cut;
            end else begin
                if ($urandom_range(0, 5) == 0) len = last_pos + 1;
                else len = $urandom_range(1, last_pos + 1);
                for (i = 0; i < len - 1; i++) begin
                    b = 8'($urandom_range(0, 127));
                    b[7] = 1'b1;
                    send_byte(b, 1'b0);
                end
                if (len == last_pos + 1) begin
                    if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(0, 255));
                    else b = 8'($urandom_range(0, limit - 1));
                end else begin
                    b = 8'($urandom_range(0, 127));
                    if ($urandom_range(0, 7) == 0) b = 8'h00;
                end
                send_byte(b, $urandom_range(0, 7) == 0);
                sent += len;
            end
        end
    endtask

    // sink stalls
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (idling_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 15);
                m_ready = 1'b0;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_varints.size() == 0) begin
                $error("unexpected beat: decoded_value %h encoded_length %0d status %0d",
                       m_data.decoded_value, m_data.encoded_length, m_data.status);
                fail_count++;
            end else begin
                want = expected_varints.pop_front();
                if (m_data.decoded_value !== want.decoded_value) begin
                    $error("decoded_value: expected %h actual %h",
                           want.decoded_value, m_data.decoded_value);
                    fail_count++;
                end
                if (m_data.encoded_length !== want.encoded_length) begin
                    $error("encoded_length: expected %0d actual %0d",
                           want.encoded_length, m_data.encoded_length);
                    fail_count++;
                end
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, m_data.status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("varint_stream_decoder regression: fail");
            $finish;
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        model_wide  = 1'b1;
        model_canon = 1'b0;
        acc_value   = '0;
        acc_pos     = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_wide_defaults();
        test_narrow_limits();
        test_canonical_form();
        test_mode_switch_mid_varint();

        set_config(1'b1, 1'b0);
        test_random_stream(140);
        set_config(1'b0, 1'b0);
        test_random_stream(140);
        set_config(1'b0, 1'b1);
        test_random_stream(140);
        set_config(1'b1, 1'b1);
        test_random_stream(140);
        set_config(1'b1, 1'b0);
        idling_on = 1'b0;
        test_random_stream(140);

        wait_idle();
        if (fail_count == 0)
            $display("varint_stream_decoder regression: pass");
        else
            $display("varint_stream_decoder regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/vsd_pkg.sv
rtl/vsd_step.sv
rtl/vsd_out_reg.sv
rtl/varint_stream_decoder.sv
dv/tb_top.sv
